/* hdl/rwpd_pkg.sv */
// Shared types and constants for the RIFF/WAVE PCM deframer.
`timescale 1ns / 1ps
`default_nettype none
package rwpd_pkg;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_TAG    = 3'd1,
    PH_LENGTH = 3'd2,
    PH_FMT    = 3'd3,
    PH_SKIP   = 3'd4,
    PH_PAD    = 3'd5,
    PH_DATA   = 3'd6,
    PH_DONE   = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    ST_SAMPLE    = 3'd0,
    ST_END       = 3'd1,
    ST_BAD_RIFF  = 3'd2,
    ST_BAD_CHUNK = 3'd3,
    ST_NOT_PCM   = 3'd4,
    ST_NOT_MONO  = 3'd5,
    ST_BAD_DEPTH = 3'd6,
    ST_TRUNCATED = 3'd7
  } status_e;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] IDX_RIFF_END = 32'd3;
  localparam logic [31:0] IDX_HDR_END  = 32'd11;
  localparam logic [31:0] IDX_WORD_END = 32'd3;
  localparam logic [31:0] FMT_MIN_LEN  = 32'd16;

  localparam logic [15:0] FMT_PCM  = 16'd1;
  localparam logic [15:0] CH_MONO  = 16'd1;
  localparam logic [15:0] DEPTH_16 = 16'd16;
  localparam logic [15:0] DEPTH_24 = 16'd24;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    logic signed [15:0] sample_value;
    logic [31:0]        sample_rate;
    logic [2:0]         status;
    logic               last_result;
  } out_t;

  typedef struct packed {
    logic signed [15:0] sample;
    status_e            status;
    logic               last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t entry;
  } res_beat_t;

endpackage
`default_nettype wire

/* hdl/rwpd_stream_if.sv */
// Valid/ready stream interface carrying one payload per beat.
`timescale 1ns / 1ps
`default_nettype none
interface rwpd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* hdl/rwpd_front.sv */
// Front end: byte parser that walks the RIFF chunks and classifies each beat.
`timescale 1ns / 1ps
`default_nettype none
module rwpd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                end_of_file_i,
  input  logic                space_i,
  output rwpd_pkg::res_beat_t push_o,
  output logic [31:0]         rate_o
);
  import rwpd_pkg::*;

  phase_e      phase_q, phase_d, adv;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic [15:0] afmt_q, afmt_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] depth_q, depth_d;
  logic        fmt_seen_q, fmt_seen_d;
  logic        sb3_q, sb3_d;
  logic [1:0]  bis_q, bis_d;

  logic        acc;
  logic [31:0] tag_shift, len_shift, cnt_inc;
  logic        body_end, whole, tail;
  logic [1:0]  bis_inc;
  result_t     res;
  logic        res_vld;

  assign in_ready_o = space_i;
  assign acc        = in_valid_i & space_i;
  assign tag_shift  = {data_byte_i, tag_q[31:8]};
  assign len_shift  = {data_byte_i, len_q[31:8]};
  assign cnt_inc    = cnt_q + 32'd1;
  assign body_end   = (cnt_inc == len_q);
  assign bis_inc    = bis_q + 2'd1;
  assign whole      = (bis_inc >= {1'b1, sb3_q});
  assign rate_o     = rate_q;

  // Decode: result of this byte, phase to advance to, datapath updates
  always_comb begin
    adv        = phase_q;
    res_vld    = 1'b0;
    res.sample = '0;
    res.status = ST_SAMPLE;
    res.last   = 1'b0;
    tail       = 1'b0;
    cnt_d      = cnt_q;
    tag_d      = tag_q;
    len_d      = len_q;
    afmt_d     = afmt_q;
    chan_d     = chan_q;
    rate_d     = rate_q;
    depth_d    = depth_q;
    fmt_seen_d = fmt_seen_q;
    sb3_d      = sb3_q;
    bis_d      = bis_q;
    case (phase_q)
      PH_HEADER: begin
        tag_d = tag_shift;
        if ((cnt_q == IDX_RIFF_END && tag_shift != TAG_RIFF) ||
            (cnt_q == IDX_HDR_END && tag_shift != TAG_WAVE)) begin
          res_vld    = 1'b1;
          res.status = ST_BAD_RIFF;
          res.last   = 1'b1;
        end else if (cnt_q == IDX_HDR_END) begin
          adv   = PH_TAG;
          cnt_d = '0;
          tail  = 1'b1;
        end else begin
          cnt_d = cnt_inc;
          tail  = 1'b1;
        end
      end
      PH_TAG: begin
        tag_d = tag_shift;
        tail  = 1'b1;
        if (cnt_q == IDX_WORD_END) begin
          adv   = PH_LENGTH;
          cnt_d = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_LENGTH: begin
        len_d = len_shift;
        if (cnt_q != IDX_WORD_END) begin
          cnt_d = cnt_inc;
          tail  = 1'b1;
        end else begin
          cnt_d = '0;
          if (tag_q == TAG_FMT) begin
            if (len_shift < FMT_MIN_LEN) begin
              res_vld    = 1'b1;
              res.status = ST_BAD_CHUNK;
              res.last   = 1'b1;
            end else begin
              adv  = PH_FMT;
              tail = 1'b1;
            end
          end else if (tag_q == TAG_DATA) begin
            res_vld  = 1'b1;
            res.last = 1'b1;
            if (!fmt_seen_q) begin
              res.status = ST_BAD_CHUNK;
            end else if (afmt_q != FMT_PCM) begin
              res.status = ST_NOT_PCM;
            end else if (chan_q != CH_MONO) begin
              res.status = ST_NOT_MONO;
            end else if (depth_q != DEPTH_16 && depth_q != DEPTH_24) begin
              res.status = ST_BAD_DEPTH;
            end else begin
              sb3_d = (depth_q == DEPTH_24);
              bis_d = '0;
              if (len_shift == '0) begin
                res.status = ST_END;
              end else begin
                adv = PH_DATA;
                if (end_of_file_i) begin
                  res.status = ST_TRUNCATED;
                end else begin
                  res_vld  = 1'b0;
                  res.last = 1'b0;
                end
              end
            end
          end else begin
            tail = 1'b1;
            adv  = (len_shift == '0) ? PH_TAG : PH_SKIP;
          end
        end
      end
      PH_FMT: begin
        tail = 1'b1;
        if (cnt_q == 32'd0) afmt_d = {8'd0, data_byte_i};
        if (cnt_q == 32'd1) afmt_d[15:8] = data_byte_i;
        if (cnt_q == 32'd2) chan_d = {8'd0, data_byte_i};
        if (cnt_q == 32'd3) chan_d[15:8] = data_byte_i;
        if (cnt_q == 32'd4) rate_d = {24'd0, data_byte_i};
        if (cnt_q == 32'd5) rate_d[15:8] = data_byte_i;
        if (cnt_q == 32'd6) rate_d[23:16] = data_byte_i;
        if (cnt_q == 32'd7) rate_d[31:24] = data_byte_i;
        if (cnt_q == 32'd14) depth_d = {8'd0, data_byte_i};
        if (cnt_q == 32'd15) depth_d[15:8] = data_byte_i;
        if (body_end) begin
          fmt_seen_d = 1'b1;
          adv        = len_q[0] ? PH_PAD : PH_TAG;
          cnt_d      = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_SKIP: begin
        tail = 1'b1;
        if (body_end) begin
          adv   = len_q[0] ? PH_PAD : PH_TAG;
          cnt_d = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_PAD: begin
        tail  = 1'b1;
        adv   = PH_TAG;
        cnt_d = '0;
      end
      PH_DATA: begin
        tag_d = tag_shift;
        cnt_d = cnt_inc;
        bis_d = whole ? 2'd0 : bis_inc;
        if (body_end) begin
          res_vld  = 1'b1;
          res.last = 1'b1;
          if (whole) begin
            res.sample = tag_shift[31:16];
          end else begin
            res.status = ST_END;
          end
        end else if (end_of_file_i) begin
          res_vld    = 1'b1;
          res.last   = 1'b1;
          res.status = ST_TRUNCATED;
        end else if (whole) begin
          res_vld    = 1'b1;
          res.sample = tag_shift[31:16];
        end
      end
      default: begin
      end
    endcase
    if (tail && end_of_file_i) begin
      res_vld    = 1'b1;
      res.last   = 1'b1;
      res.status = (adv == PH_HEADER) ? ST_BAD_RIFF : ST_BAD_CHUNK;
    end
  end

  // Next state
  always_comb begin
    phase_d = phase_q;
    if (acc) begin
      phase_d = (res_vld && res.last) ? PH_DONE : adv;
    end
  end

  // Outputs
  always_comb begin
    push_o.valid = acc & res_vld;
    push_o.entry = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      cnt_q      <= '0;
      tag_q      <= '0;
      len_q      <= '0;
      afmt_q     <= '0;
      chan_q     <= '0;
      rate_q     <= '0;
      depth_q    <= '0;
      fmt_seen_q <= 1'b0;
      sb3_q      <= 1'b0;
      bis_q      <= '0;
    end else begin
      phase_q <= phase_d;
      if (acc && phase_q != PH_DONE) begin
        cnt_q      <= cnt_d;
        tag_q      <= tag_d;
        len_q      <= len_d;
        afmt_q     <= afmt_d;
        chan_q     <= chan_d;
        rate_q     <= rate_d;
        depth_q    <= depth_d;
        fmt_seen_q <= fmt_seen_d;
        sb3_q      <= sb3_d;
        bis_q      <= bis_d;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid && push_o.entry.last |=> phase_q == PH_DONE)
    else $error("final result did not close the stream");
  a_quiet_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DONE |-> !push_o.valid)
    else $error("result after final result");
`endif
endmodule
`default_nettype wire

/* hdl/rwpd_queue.sv */
// Small result queue between the parser and the output stage.
`timescale 1ns / 1ps
`default_nettype none
module rwpd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rwpd_pkg::res_beat_t push_i,
  output logic                space_o,
  output rwpd_pkg::res_beat_t head_o,
  input  logic                pop_i
);
  import rwpd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  result_t          mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign space_o      = (cnt_q != CNT_FULL);
  assign do_push      = push_i.valid & space_o;
  assign do_pop       = pop_i & head_o.valid;
  assign head_o.valid = (cnt_q != '0);
  assign head_o.entry = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
    if (do_pop) rd_d = (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_i.entry;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == CNT_FULL |-> !(push_i.valid && !pop_i))
    else $error("result pushed into full queue");
`endif
endmodule
`default_nettype wire

/* hdl/rwpd_back.sv */
// Back end: output register that forms the result beat and holds it under stall.
`timescale 1ns / 1ps
`default_nettype none
module rwpd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rwpd_pkg::res_beat_t head_i,
  output logic                pop_o,
  input  logic [31:0]         rate_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rwpd_pkg::out_t      out_o
);
  import rwpd_pkg::*;

  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;

  assign pop_o = head_i.valid & (~out_valid_q | out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;
    if (pop_o) begin
      out_valid_d        = 1'b1;
      out_d.sample_value = (head_i.entry.status == ST_SAMPLE) ? head_i.entry.sample : '0;
      out_d.sample_rate  = rate_i;
      out_d.status       = head_i.entry.status;
      out_d.last_result  = head_i.entry.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef NO_ASSERTIONS
  a_zero_on_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != ST_SAMPLE |-> out_q.sample_value == '0)
    else $error("nonzero sample on a status beat");
`endif
endmodule
`default_nettype wire

/* hdl/riff_wave_pcm_deframer_unit.sv */
// Top level of the RIFF/WAVE PCM deframer: byte stream in, 16-bit samples out.
//
//   port    dir  beat payload
//   in_i    in   data_byte, end_of_file (one file byte)
//   out_o   out  sample_value, sample_rate, status, last_result (at most one per input beat)
//
// One byte is taken per cycle while the queue has space; the parser state is registered on each accepted byte.
// A result leaves through the queue and then the output register.
// in_i stalls only when the QUEUE_DEPTH-entry queue is full.
// Reset clears the parser to the header phase and empties queue and output.
// After the final result every byte is taken and dropped until reset.
`timescale 1ns / 1ps
`default_nettype none
module riff_wave_pcm_deframer_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rwpd_stream_if.sink   in_i,
  rwpd_stream_if.source out_o
);
  import rwpd_pkg::*;

  res_beat_t   push, head;
  logic        space, pop;
  logic [31:0] rate;
  out_t        out_pl;

  rwpd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .data_byte_i  (in_i.payload.data_byte),
    .end_of_file_i(in_i.payload.end_of_file),
    .space_i      (space),
    .push_o       (push),
    .rate_o       (rate)
  );

  rwpd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .space_o(space),
    .head_o (head),
    .pop_i  (pop)
  );

  rwpd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .rate_i     (rate),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .out_o      (out_pl)
  );

  assign out_o.payload = out_pl;
endmodule
`default_nettype wire
